FILE: rtl/raster_file_stream_decoder_macros.svh
// ---------------------------------------------------------------------------
// Raster file stream decoder assertion macros
// Concurrent check wrappers clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef RASTER_FILE_STREAM_DECODER_MACROS_SVH
`define RASTER_FILE_STREAM_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check cons in the cycle after ante
`define RFSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfsd check failed: next-cycle property");
// Check cons in the same cycle as ante
`define RFSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfsd check failed: same-cycle property");
`else
`define RFSD_ASSERT_NEXT(lbl, ante, cons)
`define RFSD_ASSERT_NOW(lbl, ante, cons)
`endif
`endif

FILE: rtl/rfsd_pkg.sv
// ---------------------------------------------------------------------------
// rfsd_pkg
// Shared types and constants of the raster file stream decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfsd_pkg;

  // Result kinds, carried on m_tuser
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_RUN     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [31:0] MAGIC_BE = 32'h59a6_6a95;
  localparam logic [31:0] MAGIC_LE = 32'h956a_a659;
  localparam logic [7:0]  ESCAPE   = 8'h80;

  localparam int PAYLOAD_W = 140;
  localparam int TDATA_W   = 144;

  // Result payload, last member in the lowest bits
  typedef struct packed {
    logic [8:0]  run_length;
    logic [7:0]  byte_value;
    logic [1:0]  channel;
    logic [7:0]  palette_index;
    logic [31:0] row_bytes;
    logic [8:0]  palette_count;
    logic        rgb_order;
    logic        compressed;
    logic [5:0]  depth;
    logic [31:0] height;
    logic [31:0] width;
  } payload_t;

  // Header parser status towards the top level
  typedef struct packed {
    logic        magic_bad;
    logic        last;
    logic        ok;
    logic [8:0]  palette_count;
    logic [31:0] row_bytes;
    logic [31:0] width;
    logic [31:0] height;
    logic [5:0]  depth;
    logic        compressed;
    logic        rgb_order;
  } hdr_info_t;

  // Body decoder status towards the top level
  typedef struct packed {
    logic       pal_last;
    logic [7:0] palette_index;
    logic [1:0] channel;
    logic       img_valid;
    logic [7:0] img_value;
    logic [8:0] img_len;
  } body_info_t;

endpackage

FILE: rtl/rfsd_header.sv
// ---------------------------------------------------------------------------
// rfsd_header
// Gathers the 32-byte header, checks magic and fields, and works out the
// row byte count and palette entry count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfsd_header #(
  parameter int MAX_PALETTE = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  output rfsd_pkg::hdr_info_t  info
);

  localparam logic [8:0] MAX_PAL = 9'(MAX_PALETTE);

  logic [4:0]  header_count;
  logic [31:0] word_shift;
  logic        little_endian;
  logic [31:0] width;
  logic [31:0] height;
  logic [5:0]  depth;
  logic        depth_ok;
  logic [1:0]  type_low;
  logic        type_ok;
  logic        map_rgb;
  logic        map_ok;
  logic [31:0] product;

  logic [31:0] word_next;
  logic [31:0] word_val;
  logic        word_end;
  logic [2:0]  widx;
  logic [19:0] third;
  logic [8:0]  quot;
  logic [8:0]  pal_raw;
  logic [8:0]  pal_cnt;
  logic [31:0] rounded;
  logic [31:0] row_half;
  logic [31:0] row_even;

  // Assemble the current word in file order and in chosen byte order
  assign word_next = {word_shift[23:0], data_byte};
  assign word_val  = little_endian ?
                     {word_next[7:0], word_next[15:8], word_next[23:16], word_next[31:24]}
                     : word_next;
  assign word_end  = (header_count[1:0] == 2'd3);
  assign widx      = header_count[4:2];

  // Map length divided by three via reciprocal, valid below 768
  assign third   = 20'(word_val[9:0]) * 20'd683;
  assign quot    = third[19:11];
  assign pal_raw = (word_val >= 32'd768) ? 9'd256 : quot;
  always_comb begin
    pal_cnt = (pal_raw > MAX_PAL) ? MAX_PAL : pal_raw;
    if (!(map_rgb && depth <= 6'd8)) begin
      pal_cnt = '0;
    end
  end

  // Round width*depth bits up to bytes, then to an even count
  assign rounded  = product + 32'd7;
  assign row_half = {3'b000, rounded[31:3]};
  assign row_even = (row_half + 32'd1) & ~32'd1;

  // Status towards the top level
  always_comb begin
    info.magic_bad     = take && (header_count == 5'd3) &&
                         (word_next != rfsd_pkg::MAGIC_LE) &&
                         (word_next != rfsd_pkg::MAGIC_BE);
    info.last          = (header_count == 5'd31);
    info.ok            = (width != '0) && (height != '0) && type_ok && map_ok && depth_ok;
    info.palette_count = pal_cnt;
    info.row_bytes     = row_even;
    info.width         = width;
    info.height        = height;
    info.depth         = depth;
    info.compressed    = type_ok && (type_low == 2'd2);
    info.rgb_order     = type_ok && (type_low == 2'd3);
  end

  // Advance the byte count and word shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      word_shift    <= '0;
      little_endian <= 1'b0;
    end else if (take) begin
      word_shift   <= word_next;
      header_count <= header_count + 5'd1;
      if (header_count == 5'd3) begin
        little_endian <= (word_next == rfsd_pkg::MAGIC_LE);
      end
    end
  end

  // Capture header words as they complete
  always_ff @(posedge clk) begin
    product <= width * 32'(depth);
    if (take && word_end) begin
      unique case (widx)
        3'd1: width  <= word_val;
        3'd2: height <= word_val;
        3'd3: begin
          depth    <= word_val[5:0];
          depth_ok <= (word_val == 32'd1) || (word_val == 32'd8) ||
                      (word_val == 32'd24) || (word_val == 32'd32);
        end
        3'd5: begin
          type_low <= word_val[1:0];
          type_ok  <= (word_val <= 32'd3);
        end
        3'd6: begin
          map_rgb <= (word_val == 32'd1);
          map_ok  <= (word_val <= 32'd1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/rfsd_body.sv
// ---------------------------------------------------------------------------
// rfsd_body
// Walks the colour map planes and decodes image bytes, with the 0x80
// escape when the data is run-length coded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfsd_body (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [8:0]            start_size,
  input  logic                  compressed,
  input  logic                  take_pal,
  input  logic                  take_img,
  input  logic [7:0]            data_byte,
  output rfsd_pkg::body_info_t  info
);

  localparam logic [1:0] RL_START = 2'd0;
  localparam logic [1:0] RL_COUNT = 2'd1;
  localparam logic [1:0] RL_VALUE = 2'd2;

  logic [8:0] pal_size;
  logic [7:0] pal_idx;
  logic [1:0] pal_ch;
  logic [1:0] rle_phase;
  logic [7:0] run_count;

  logic       plane_end;
  logic [1:0] rle_next;
  logic       run_load;

  assign plane_end = ({1'b0, pal_idx} + 9'd1) == pal_size;

  // Palette position and image decode
  always_comb begin
    info.pal_last      = plane_end && (pal_ch == 2'd2);
    info.palette_index = pal_idx;
    info.channel       = pal_ch;
    info.img_valid     = 1'b1;
    info.img_value     = data_byte;
    info.img_len       = 9'd1;
    rle_next           = RL_START;
    run_load           = 1'b0;
    if (compressed) begin
      unique case (rle_phase)
        RL_COUNT: begin
          if (data_byte != 8'd0) begin
            info.img_valid = 1'b0;
            run_load       = 1'b1;
            rle_next       = RL_VALUE;
          end else begin
            info.img_value = rfsd_pkg::ESCAPE;
          end
        end
        RL_VALUE: begin
          info.img_len = {1'b0, run_count} + 9'd1;
        end
        default: begin
          if (data_byte == rfsd_pkg::ESCAPE) begin
            info.img_valid = 1'b0;
            rle_next       = RL_COUNT;
          end
        end
      endcase
    end
  end

  // Advance palette plane and index
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_size <= '0;
      pal_idx  <= '0;
      pal_ch   <= '0;
    end else if (start) begin
      pal_size <= start_size;
      pal_idx  <= '0;
      pal_ch   <= '0;
    end else if (take_pal) begin
      if (plane_end) begin
        pal_idx <= '0;
        pal_ch  <= pal_ch + 2'd1;
      end else begin
        pal_idx <= pal_idx + 8'd1;
      end
    end
  end

  // Hold escape state between image bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_phase <= RL_START;
      run_count <= '0;
    end else if (start) begin
      rle_phase <= RL_START;
      run_count <= '0;
    end else if (take_img && compressed) begin
      rle_phase <= rle_next;
      if (run_load) begin
        run_count <= data_byte;
      end
    end
  end

endmodule

FILE: rtl/raster_file_stream_decoder.sv
// ---------------------------------------------------------------------------
// raster_file_stream_decoder
// Decodes a raster image file fed one byte per word on the s_ side.
// The first 32 bytes form the header; one header word (kind 0) or an error
// word (kind 3) leaves on the m_ side, kind on m_tuser. Colour map bytes
// follow as palette words (kind 1), red plane, green plane, blue plane.
// Image bytes then leave as run words (kind 2), a run of one each or
// expanded from the 0x80 escape when the header type is 2. After an error
// every byte is taken and dropped until reset.
// Each byte is decoded in the cycle it is taken; its result appears on the
// m_ side in the cycle after. One byte is taken every cycle while the output
// register is empty or being drained; the output register is the only
// stage. Some bytes (header, escape prefix) give no word.
// Reset (rst, synchronous) returns to header collection and empties the
// output register. While m_tready is low a held word stalls s_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "raster_file_stream_decoder_macros.svh"

module raster_file_stream_decoder #(
  parameter int MAX_PALETTE = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // data_byte[7:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // width[31:0], height[63:32], depth[69:64], compressed[70], rgb_order[71],
  // palette_count[80:72], row_bytes[112:81], palette_index[120:113],
  // channel[122:121], byte_value[130:123], run_length[139:131], zeros above
  output logic [rfsd_pkg::TDATA_W-1:0]  m_tdata,
  output logic [1:0]                    m_tuser   // kind[1:0]
);

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PALETTE = 2'd1;
  localparam logic [1:0] PH_IMAGE   = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  logic [1:0]            phase;
  logic [1:0]            phase_next;
  logic                  accept;
  logic                  res_valid;
  logic [1:0]            res_kind;
  rfsd_pkg::payload_t    res;
  rfsd_pkg::payload_t    out_payload;
  rfsd_pkg::hdr_info_t   hdr;
  rfsd_pkg::body_info_t  body;
  logic                  body_start;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  rfsd_header #(
    .MAX_PALETTE (MAX_PALETTE)
  ) u_header (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && (phase == PH_HEADER)),
    .data_byte (s_tdata),
    .info      (hdr)
  );

  rfsd_body u_body (
    .clk        (clk),
    .rst        (rst),
    .start      (body_start),
    .start_size (hdr.palette_count),
    .compressed (hdr.compressed),
    .take_pal   (accept && (phase == PH_PALETTE)),
    .take_img   (accept && (phase == PH_IMAGE)),
    .data_byte  (s_tdata),
    .info       (body)
  );

  // Select the result word and next phase for the current byte
  always_comb begin
    res        = '0;
    res_kind   = rfsd_pkg::KIND_ERROR;
    res_valid  = 1'b0;
    phase_next = phase;
    body_start = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        if (hdr.magic_bad) begin
          res_valid  = 1'b1;
          phase_next = PH_ERROR;
        end else if (hdr.last) begin
          res_valid = 1'b1;
          if (hdr.ok) begin
            res_kind          = rfsd_pkg::KIND_HEADER;
            res.width         = hdr.width;
            res.height        = hdr.height;
            res.depth         = hdr.depth;
            res.compressed    = hdr.compressed;
            res.rgb_order     = hdr.rgb_order;
            res.palette_count = hdr.palette_count;
            res.row_bytes     = hdr.row_bytes;
            body_start        = accept;
            phase_next        = (hdr.palette_count != '0) ? PH_PALETTE : PH_IMAGE;
          end else begin
            phase_next = PH_ERROR;
          end
        end
      end
      PH_PALETTE: begin
        res_valid         = 1'b1;
        res_kind          = rfsd_pkg::KIND_PALETTE;
        res.palette_index = body.palette_index;
        res.channel       = body.channel;
        res.byte_value    = s_tdata;
        if (body.pal_last) begin
          phase_next = PH_IMAGE;
        end
      end
      PH_IMAGE: begin
        res_valid      = body.img_valid;
        res_kind       = rfsd_pkg::KIND_RUN;
        res.byte_value = body.img_value;
        res.run_length = body.img_len;
      end
      default: begin
      end
    endcase
  end

  // Advance the decode phase on each taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Output register: load on a taken byte, drop once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_payload <= res;
      m_tuser     <= res_kind;
    end
  end

  assign m_tdata = {{(rfsd_pkg::TDATA_W - rfsd_pkg::PAYLOAD_W){1'b0}}, out_payload};

  // Checks
  `RFSD_ASSERT_NEXT(a_error_sticky, phase == PH_ERROR, phase == PH_ERROR)
  `RFSD_ASSERT_NEXT(a_error_silent, accept && (phase == PH_ERROR), !m_tvalid)
  `RFSD_ASSERT_NEXT(a_palette_word, accept && (phase == PH_PALETTE),
                    m_tvalid && (m_tuser == rfsd_pkg::KIND_PALETTE))
  `RFSD_ASSERT_NEXT(a_header_leaves, accept && (phase == PH_HEADER) && hdr.last,
                    (phase != PH_HEADER) && m_tvalid)
  `RFSD_ASSERT_NOW(a_start_in_header, body_start, phase == PH_HEADER)

endmodule

FILE: sim/raster_file_stream_decoder_tb.sv
// ---------------------------------------------------------------------------
// raster_file_stream_decoder_tb
// Feeds one raster file per run into the decoder: a header with random
// byte order, image size, depth, image type and colour map, optionally
// spoilt by a bad magic or a bad header field, then the colour map planes
// and image bytes with run-length escapes. A local decoder model predicts
// every output word, and each word taken on the m_ side is checked field by
// field against the oldest prediction. Both sides idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module raster_file_stream_decoder_tb;

  localparam int PAL_MAX      = 256;
  localparam int FILE_LEN     = 2000;
  localparam int STALL_LIMIT  = 2000;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 900;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 40;

  typedef enum logic [1:0] {ST_HEADER, ST_PALETTE, ST_IMAGE, ST_DROP} read_state_t;
  typedef enum logic [1:0] {ESC_NONE, ESC_COUNT, ESC_VALUE} esc_state_t;

  typedef struct packed {
    logic [1:0]          kind;
    rfsd_pkg::payload_t  pl;
  } file_word_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic [7:0]                    s_tdata  = 8'd0;
  logic                          m_tready = 1'b0;
  logic                          s_tready;
  logic                          m_tvalid;
  logic [rfsd_pkg::TDATA_W-1:0]  m_tdata;
  logic [1:0]                    m_tuser;

  raster_file_stream_decoder #(
    .MAX_PALETTE (PAL_MAX)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // File bytes still to send and decoded words still to arrive
  logic [7:0]  file_bytes [$];
  file_word_t  pending_words [$];

  logic [31:0] cyc          = 32'd0;
  int          stall_cycles = 0;
  int          errors       = 0;

  // Decoder model state
  read_state_t rd_state      = ST_HEADER;
  logic [4:0]  hdr_cnt       = 5'd0;
  logic [31:0] shift_word    = 32'd0;
  logic        le_file       = 1'b0;
  logic [31:0] hdr_word [7]  = '{default: 32'd0};
  logic [8:0]  pal_entries   = 9'd0;
  logic [9:0]  pal_pos       = 10'd0;
  esc_state_t  esc_state     = ESC_NONE;
  logic [7:0]  esc_count     = 8'd0;

  file_word_t          want_word;
  file_word_t          next_word;
  rfsd_pkg::payload_t  got_pl;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Random idle, switched off through the quiet stretch
  function automatic bit hold_off();
    return (cyc < QUIET_FROM || cyc > QUIET_TO) && ($urandom_range(0, 99) < 10);
  endfunction

  // Advance the model by one file byte; return 1 when it yields a word
  function automatic bit decode_byte(input logic [7:0] b, output file_word_t r);
    logic [31:0] w, h, d, ftype, mtype, rb, pc, n, p;
    r = '0;
    case (rd_state)
      ST_HEADER: begin
        shift_word = {shift_word[23:0], b};
        if (hdr_cnt[1:0] == 2'd3) begin
          if (hdr_cnt[4:2] == 3'd0) begin
            if (shift_word == rfsd_pkg::MAGIC_LE) begin
              le_file = 1'b1;
            end else if (shift_word == rfsd_pkg::MAGIC_BE) begin
              le_file = 1'b0;
            end else begin
              rd_state = ST_DROP;
              r.kind = rfsd_pkg::KIND_ERROR;
              return 1'b1;
            end
          end else begin
            hdr_word[hdr_cnt[4:2] - 3'd1] = le_file ? byte_swap(shift_word) : shift_word;
          end
        end
        if (hdr_cnt != 5'd31) begin
          hdr_cnt = hdr_cnt + 5'd1;
          return 1'b0;
        end
        hdr_cnt = 5'd0;
        w     = hdr_word[0];
        h     = hdr_word[1];
        d     = hdr_word[2];
        ftype = hdr_word[4];
        mtype = hdr_word[5];
        if (w == 32'd0 || h == 32'd0 || ftype > 32'd3 || mtype > 32'd1 ||
            (d != 32'd1 && d != 32'd8 && d != 32'd24 && d != 32'd32)) begin
          rd_state = ST_DROP;
          r.kind = rfsd_pkg::KIND_ERROR;
          return 1'b1;
        end
        // Row length wraps at 32 bits, then rounds up to even
        rb = (w * d + 32'd7) >> 3;
        rb = (rb + 32'd1) & ~32'd1;
        pc = 32'd0;
        if (mtype == 32'd1 && d <= 32'd8) begin
          pc = hdr_word[6] / 32'd3;
          if (pc > PAL_MAX) pc = PAL_MAX;
        end
        pal_entries = pc[8:0];
        pal_pos     = 10'd0;
        esc_state   = ESC_NONE;
        esc_count   = 8'd0;
        rd_state    = (pc != 32'd0) ? ST_PALETTE : ST_IMAGE;
        r.kind             = rfsd_pkg::KIND_HEADER;
        r.pl.width         = w;
        r.pl.height        = h;
        r.pl.depth         = d[5:0];
        r.pl.compressed    = (ftype == 32'd2);
        r.pl.rgb_order     = (ftype == 32'd3);
        r.pl.palette_count = pc[8:0];
        r.pl.row_bytes     = rb;
        return 1'b1;
      end
      ST_PALETTE: begin
        n = {23'd0, pal_entries};
        p = {22'd0, pal_pos};
        if (p + 32'd1 >= 32'd3 * n) rd_state = ST_IMAGE;
        pal_pos = pal_pos + 10'd1;
        r.kind = rfsd_pkg::KIND_PALETTE;
        r.pl.byte_value = b;
        if (p >= 32'd2 * n) begin
          r.pl.channel = 2'd2;
          p = p - 32'd2 * n;
        end else if (p >= n) begin
          r.pl.channel = 2'd1;
          p = p - n;
        end
        r.pl.palette_index = p[7:0];
        return 1'b1;
      end
      ST_IMAGE: begin
        r.kind = rfsd_pkg::KIND_RUN;
        r.pl.run_length = 9'd1;
        r.pl.byte_value = b;
        // Plain images pass every byte as a run of one
        if (hdr_word[4] != 32'd2) return 1'b1;
        case (esc_state)
          ESC_COUNT: begin
            if (b != 8'd0) begin
              esc_count = b;
              esc_state = ESC_VALUE;
              return 1'b0;
            end
            esc_state = ESC_NONE;
            r.pl.byte_value = rfsd_pkg::ESCAPE;
            return 1'b1;
          end
          ESC_VALUE: begin
            esc_state = ESC_NONE;
            r.pl.run_length = {1'b0, esc_count} + 9'd1;
            return 1'b1;
          end
          default: begin
            if (b == rfsd_pkg::ESCAPE) begin
              esc_state = ESC_COUNT;
              return 1'b0;
            end
            return 1'b1;
          end
        endcase
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic push_be(input logic [31:0] v);
    file_bytes.push_back(v[31:24]);
    file_bytes.push_back(v[23:16]);
    file_bytes.push_back(v[15:8]);
    file_bytes.push_back(v[7:0]);
  endtask

  // Byte source: offer the next byte once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'd0;
    end else if (!s_tvalid || s_tready) begin
      if (file_bytes.size() != 0 && !hold_off()) begin
        s_tdata  <= file_bytes.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Word sink: stall at random
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !hold_off();
  end

  // Check words taken, predict from bytes taken, track stalls
  always @(posedge clk) begin
    if (!rst) begin
      cyc <= cyc + 32'd1;
      if (m_tvalid && m_tready) begin
        got_pl = rfsd_pkg::payload_t'(m_tdata[rfsd_pkg::PAYLOAD_W-1:0]);
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("word of kind %0d with none pending", m_tuser));
        end else begin
          want_word = pending_words.pop_front();
          check_field("kind", 32'(m_tuser), 32'(want_word.kind));
          check_field("width", got_pl.width, want_word.pl.width);
          check_field("height", got_pl.height, want_word.pl.height);
          check_field("depth", 32'(got_pl.depth), 32'(want_word.pl.depth));
          check_field("compressed", 32'(got_pl.compressed),
                      32'(want_word.pl.compressed));
          check_field("rgb_order", 32'(got_pl.rgb_order), 32'(want_word.pl.rgb_order));
          check_field("palette_count", 32'(got_pl.palette_count),
                      32'(want_word.pl.palette_count));
          check_field("row_bytes", got_pl.row_bytes, want_word.pl.row_bytes);
          check_field("palette_index", 32'(got_pl.palette_index),
                      32'(want_word.pl.palette_index));
          check_field("channel", 32'(got_pl.channel), 32'(want_word.pl.channel));
          check_field("byte_value", 32'(got_pl.byte_value),
                      32'(want_word.pl.byte_value));
          check_field("run_length", 32'(got_pl.run_length),
                      32'(want_word.pl.run_length));
          check_field("padding",
                      32'(m_tdata[rfsd_pkg::TDATA_W-1:rfsd_pkg::PAYLOAD_W]), 32'd0);
        end
      end
      if (s_tvalid && s_tready) begin
        if (decode_byte(s_tdata, next_word)) pending_words.push_back(next_word);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (file_bytes.size() != 0 || s_tvalid || pending_words.size() != 0) begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Build the file, release reset, wait for the last word
  initial begin
    int unsigned scenario, k, n_pal;
    logic [31:0] hw [7];
    logic [31:0] bad;
    bit          le_stream;
    logic [7:0]  b;

    // One in ten files has a bad magic, one in ten a bad header
    scenario  = $urandom_range(0, 9);
    le_stream = 1'($urandom_range(0, 1));

    case ($urandom_range(0, 4))
      0:       hw[0] = 32'd1;
      1:       hw[0] = 32'hffff_ffff;
      2:       hw[0] = 32'h8000_0000;
      3:       hw[0] = $urandom() | 32'd1;
      default: hw[0] = $urandom_range(1, 5000);
    endcase
    case ($urandom_range(0, 2))
      0:       hw[1] = 32'd1;
      1:       hw[1] = 32'hffff_ffff;
      default: hw[1] = $urandom() | 32'd1;
    endcase
    case ($urandom_range(0, 3))
      0:       hw[2] = 32'd1;
      1:       hw[2] = 32'd8;
      2:       hw[2] = 32'd24;
      default: hw[2] = 32'd32;
    endcase
    hw[3] = $urandom();
    hw[4] = ($urandom_range(0, 9) < 4) ? 32'd2 : $urandom_range(0, 3);
    hw[5] = ($urandom_range(0, 9) < 7) ? 32'd1 : 32'd0;
    case ($urandom_range(0, 7))
      0:       hw[6] = 32'd0;
      1:       hw[6] = $urandom_range(1, 5);
      2:       hw[6] = $urandom_range(767, 769);
      3:       hw[6] = 32'hffff_ffff;
      default: hw[6] = $urandom_range(6, 400);
    endcase

    if (scenario == 0) begin
      // Near misses of either magic, or anything at all
      case ($urandom_range(0, 2))
        0:       bad = $urandom();
        1:       bad = rfsd_pkg::MAGIC_BE ^ (32'd1 << $urandom_range(0, 31));
        default: bad = rfsd_pkg::MAGIC_LE ^ (32'd1 << $urandom_range(0, 31));
      endcase
      if (bad == rfsd_pkg::MAGIC_BE || bad == rfsd_pkg::MAGIC_LE) bad = ~bad;
      push_be(bad);
    end else begin
      push_be(le_stream ? rfsd_pkg::MAGIC_LE : rfsd_pkg::MAGIC_BE);
      if (scenario == 1) begin
        case ($urandom_range(0, 4))
          0: hw[0] = 32'd0;
          1: hw[1] = 32'd0;
          2: begin
            case ($urandom_range(0, 5))
              0:       hw[2] = 32'd0;
              1:       hw[2] = 32'd2;
              2:       hw[2] = 32'd16;
              3:       hw[2] = 32'd33;
              4:       hw[2] = 32'hffff_ffff;
              default: hw[2] = 32'd9;
            endcase
          end
          3: hw[4] = $urandom_range(0, 1) ? 32'hffff_ffff : $urandom_range(4, 255);
          default: hw[5] = $urandom_range(0, 1) ? 32'hffff_ffff : $urandom_range(2, 255);
        endcase
      end
      for (int i = 0; i < 7; i++) push_be(le_stream ? byte_swap(hw[i]) : hw[i]);
    end

    if (scenario <= 1) begin
      // Everything after an error is dropped
      while (file_bytes.size() < FILE_LEN)
        file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_pal = 0;
      if (hw[5] == 32'd1 && hw[2] <= 32'd8) n_pal = (hw[6] / 3 > PAL_MAX) ? PAL_MAX : hw[6] / 3;
      repeat (3 * n_pal) file_bytes.push_back(8'($urandom_range(0, 255)));
      // Extremes, a literal escape, the longest run and an escaped escape
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hff);
      file_bytes.push_back(rfsd_pkg::ESCAPE);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(rfsd_pkg::ESCAPE);
      file_bytes.push_back(8'hff);
      file_bytes.push_back(8'h5a);
      file_bytes.push_back(rfsd_pkg::ESCAPE);
      file_bytes.push_back(8'h01);
      file_bytes.push_back(rfsd_pkg::ESCAPE);
      file_bytes.push_back(8'h7f);
      while (file_bytes.size() < FILE_LEN) begin
        k = $urandom_range(0, 99);
        if (hw[4] != 32'd2) begin
          file_bytes.push_back(k < 15 ? rfsd_pkg::ESCAPE : 8'($urandom_range(0, 255)));
        end else if (k < 55) begin
          // Literal byte, anything but the escape
          b = 8'($urandom_range(0, 254));
          if (b >= rfsd_pkg::ESCAPE) b = b + 8'd1;
          file_bytes.push_back(b);
        end else if (k < 65) begin
          file_bytes.push_back(rfsd_pkg::ESCAPE);
          file_bytes.push_back(8'h00);
        end else if (k < 93) begin
          file_bytes.push_back(rfsd_pkg::ESCAPE);
          file_bytes.push_back(8'($urandom_range(1, 255)));
          file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          file_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (stall_cycles < STALL_LIMIT &&
           (file_bytes.size() != 0 || s_tvalid || pending_words.size() != 0))
      @(negedge clk);

    if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (errors == 0 && pending_words.size() == 0) begin
        $display("Test completed successfully");
      end else begin
        $display("Test completed with failures");
      end
    end
    $finish;
  end

endmodule
